### hdl/ofcc_pkg.sv
package ofcc_pkg;

  // Wheel and angle constants.
  localparam int unsigned WheelSize   = 55;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned SqrtSteps   = 17;
  localparam int unsigned NormStages  = 3;
  localparam int unsigned ShadeStages = 3;
  localparam int unsigned Latency     = NormStages + SqrtSteps + ShadeStages + 1;
  localparam int signed   HalfTurn    = 524288;
  localparam int signed   QuarterTurn = 262144;
  localparam int signed   NormSat     = 131072;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_NORM_RECIP   = 2'd0,
    CFG_BLEND_ENABLE = 2'd1
  } cfg_reg_e;

  // State carried through the shared square-root and CORDIC stages.
  typedef struct packed {
    logic [32:0]        rem;
    logic [33:0]        root;
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [21:0] z;
    logic               hold;
    logic               in_disk;
  } iter_t;

  localparam logic [17:0] ATAN_UNITS [CordicSteps] = '{
    18'd131072, 18'd77376, 18'd40884, 18'd20753, 18'd10417, 18'd5213, 18'd2607,
    18'd1304, 18'd652, 18'd326, 18'd163, 18'd81, 18'd41, 18'd20, 18'd10, 18'd5
  };

  localparam logic [7:0] WHEEL_R [WheelSize] = '{
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd213, 8'd170, 8'd128, 8'd85, 8'd43,
    8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd19, 8'd39, 8'd58, 8'd78, 8'd98, 8'd117, 8'd137, 8'd156, 8'd176,
    8'd196, 8'd215, 8'd235,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
  };

  localparam logic [7:0] WHEEL_G [WheelSize] = '{
    8'd0, 8'd17, 8'd34, 8'd51, 8'd68, 8'd85, 8'd102, 8'd119, 8'd136, 8'd153,
    8'd170, 8'd187, 8'd204, 8'd221, 8'd238,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd232, 8'd209, 8'd186, 8'd163, 8'd140, 8'd116, 8'd93, 8'd70, 8'd47, 8'd24,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

  localparam logic [7:0] WHEEL_B [WheelSize] = '{
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd63, 8'd127, 8'd191,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255,
    8'd255, 8'd213, 8'd170, 8'd128, 8'd85, 8'd43
  };

  // Wheel lookup; channel 0 is blue, 1 green, 2 red.
  function automatic logic [7:0] wheel_color(int unsigned ch, logic [5:0] k);
    logic [7:0] c;
    c = 8'd0;
    if (k < 6'(WheelSize)) begin
      case (ch)
        0:       c = WHEEL_B[k];
        1:       c = WHEEL_G[k];
        default: c = WHEEL_R[k];
      endcase
    end
    return c;
  endfunction

  // One restoring square-root step.
  function automatic iter_t sqrt_step(iter_t s, int unsigned i);
    logic [33:0] bitv;
    logic [33:0] trial;
    iter_t       r;
    r     = s;
    bitv  = 34'd1 << (32 - 2 * i);
    trial = s.root + bitv;
    if ({1'b0, s.rem} >= trial) begin
      r.rem  = 33'({1'b0, s.rem} - trial);
      r.root = (s.root >> 1) + bitv;
    end else begin
      r.root = s.root >> 1;
    end
    return r;
  endfunction

  // One vectoring CORDIC step; items on the x axis hold their fixed angle.
  function automatic iter_t cordic_step(iter_t s, int unsigned i);
    iter_t r;
    r = s;
    if (!s.hold) begin
      if (s.y > 0) begin
        r.x = s.x + (s.y >>> i);
        r.y = s.y - (s.x >>> i);
        r.z = s.z + $signed({4'b0, ATAN_UNITS[i]});
      end else begin
        r.x = s.x - (s.y >>> i);
        r.y = s.y + (s.x >>> i);
        r.z = s.z - $signed({4'b0, ATAN_UNITS[i]});
      end
    end
    return r;
  endfunction

endpackage

### hdl/ofcc_norm.sv
module ofcc_norm import ofcc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [15:0] flow_u_i,
  input  logic signed [15:0] flow_v_i,
  input  logic [31:0]        norm_recip_i,
  output logic               valid_o,
  output logic [32:0]        r2_o,
  output logic               inside_o,
  output logic signed [15:0] flow_u_o,
  output logic signed [15:0] flow_v_o
);

  logic [NormStages-1:0] valid_q;
  logic signed [15:0]    u_q [NormStages];
  logic signed [15:0]    v_q [NormStages];
  logic signed [48:0]    prod_u_d, prod_v_d, prod_u_q, prod_v_q;
  logic signed [35:0]    sh_u, sh_v;
  logic signed [18:0]    nu, nv;
  logic signed [37:0]    sq_u_full, sq_v_full;
  logic [34:0]           sq_u_q, sq_v_q;
  logic [35:0]           r2_sum;
  logic                  inside_d, inside_q;
  logic [32:0]           r2_d, r2_q;

  // Stage 1: scale by the reciprocal radius.
  assign prod_u_d = flow_u_i * $signed({1'b0, norm_recip_i});
  assign prod_v_d = flow_v_i * $signed({1'b0, norm_recip_i});

  // Stage 2: floor shift, saturate to 2.0 and square.
  assign sh_u = prod_u_q[48:13];
  assign sh_v = prod_v_q[48:13];

  always_comb begin
    if (sh_u > 36'(NormSat)) begin
      nu = 19'(NormSat);
    end else if (sh_u < -36'(NormSat)) begin
      nu = -19'(NormSat);
    end else begin
      nu = sh_u[18:0];
    end
    if (sh_v > 36'(NormSat)) begin
      nv = 19'(NormSat);
    end else if (sh_v < -36'(NormSat)) begin
      nv = -19'(NormSat);
    end else begin
      nv = sh_v[18:0];
    end
  end

  assign sq_u_full = nu * nu;
  assign sq_v_full = nv * nv;

  // Stage 3: squared radius and unit-circle test; outside items get a zero root.
  assign r2_sum   = {1'b0, sq_u_q} + {1'b0, sq_v_q};
  assign inside_d = (r2_sum <= 36'h1_0000_0000);
  assign r2_d     = inside_d ? r2_sum[32:0] : 33'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[NormStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_u_q <= prod_u_d;
    prod_v_q <= prod_v_d;
    sq_u_q   <= sq_u_full[34:0];
    sq_v_q   <= sq_v_full[34:0];
    r2_q     <= r2_d;
    inside_q <= inside_d;
    u_q[0]   <= flow_u_i;
    v_q[0]   <= flow_v_i;
    for (int i = 1; i < NormStages; i++) begin
      u_q[i] <= u_q[i-1];
      v_q[i] <= v_q[i-1];
    end
  end

  assign valid_o  = valid_q[NormStages-1];
  assign r2_o     = r2_q;
  assign inside_o = inside_q;
  assign flow_u_o = u_q[NormStages-1];
  assign flow_v_o = v_q[NormStages-1];

endmodule

### hdl/ofcc_iter.sv
module ofcc_iter import ofcc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [32:0]        r2_i,
  input  logic               inside_i,
  input  logic signed [15:0] flow_u_i,
  input  logic signed [15:0] flow_v_i,
  output logic               valid_o,
  output logic [16:0]        root_o,
  output logic signed [21:0] angle_o,
  output logic               inside_o
);

  logic [SqrtSteps-1:0] valid_q;
  iter_t                st_d [SqrtSteps];
  iter_t                st_q [SqrtSteps];
  iter_t                init;
  logic signed [16:0]   x0, y0;
  logic signed [32:0]   xs, ys;

  // Angle of (-u, -v): the x-axis case is fixed, the left half is pre-rotated.
  always_comb begin
    x0           = -$signed({flow_u_i[15], flow_u_i});
    y0           = -$signed({flow_v_i[15], flow_v_i});
    xs           = 33'(x0) <<< 14;
    ys           = 33'(y0) <<< 14;
    init.rem     = r2_i;
    init.root    = '0;
    init.in_disk = inside_i;
    init.hold    = 1'b0;
    init.x       = xs;
    init.y       = ys;
    init.z       = '0;
    if (y0 == 17'sd0) begin
      init.hold = 1'b1;
      init.x    = '0;
      init.y    = '0;
      init.z    = (x0 > 17'sd0) ? 22'sd0 : -22'(HalfTurn);
    end else if (x0 < 17'sd0) begin
      if (y0 > 17'sd0) begin
        init.x = ys;
        init.y = -xs;
        init.z = 22'(QuarterTurn);
      end else begin
        init.x = -ys;
        init.y = xs;
        init.z = -22'(QuarterTurn);
      end
    end
  end

  // Each stage does one root step and, after the first, one CORDIC step.
  for (genvar i = 0; i < SqrtSteps; i++) begin : g_stage
    if (i == 0) begin : g_first
      assign st_d[i] = sqrt_step(init, 0);
    end else begin : g_next
      assign st_d[i] = sqrt_step(cordic_step(st_q[i-1], i - 1), i);
    end

    always_ff @(posedge clk_i) begin
      st_q[i] <= st_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[SqrtSteps-2:0], valid_i};
    end
  end

  assign valid_o  = valid_q[SqrtSteps-1];
  assign root_o   = st_q[SqrtSteps-1].root[16:0];
  assign angle_o  = st_q[SqrtSteps-1].z;
  assign inside_o = st_q[SqrtSteps-1].in_disk;

endmodule

### hdl/ofcc_shade.sv
module ofcc_shade import ofcc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [16:0]        root_i,
  input  logic signed [21:0] angle_i,
  input  logic               inside_i,
  output logic               valid_o,
  output logic [7:0]         color_o [3]
);

  logic [ShadeStages-1:0] valid_q;
  logic signed [21:0]     zc, zs;
  logic [26:0]            t;
  logic [6:0]             k0_raw;
  logic [5:0]             k0, k1;
  logic [7:0]             c0_q [3];
  logic [7:0]             c1_q [3];
  logic [19:0]            f_q;
  logic [16:0]            root_q [2];
  logic                   inside_q [2];
  logic signed [8:0]      diff [3];
  logic signed [29:0]     part [3];
  logic signed [29:0]     mix [3];
  logic [27:0]            c_q [3];
  logic [27:0]            d [3];
  logic [45:0]            p [3];
  logic [45:0]            pc [3];
  logic [9:0]             q [3];
  logic [29:0]            c3 [3];
  logic [7:0]             o_d [3];
  logic [7:0]             o_q [3];

  // Stage 1: clamp the angle, split it into wheel index and fraction.
  always_comb begin
    if (angle_i > 22'(HalfTurn)) begin
      zc = 22'(HalfTurn);
    end else if (angle_i < -22'(HalfTurn)) begin
      zc = -22'(HalfTurn);
    end else begin
      zc = angle_i;
    end
    zs     = zc + 22'(HalfTurn);
    t      = 27'(zs[20:0]) * 27'd54;
    k0_raw = t[26:20];
    k0     = (k0_raw >= 7'(WheelSize)) ? 6'(WheelSize - 1) : k0_raw[5:0];
    k1     = (k0 == 6'(WheelSize - 1)) ? 6'd0 : k0 + 6'd1;
  end

  // Stage 2 and 3 per channel: interpolate, then desaturate or dim.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      diff[ch] = $signed({1'b0, c1_q[ch]}) - $signed({1'b0, c0_q[ch]});
      part[ch] = diff[ch] * $signed({1'b0, f_q});
      mix[ch]  = $signed({2'b00, c0_q[ch], 20'd0}) + part[ch];
      d[ch]    = 28'd267386880 - c_q[ch];
      p[ch]    = 46'(root_q[1]) * 46'(d[ch]);
      pc[ch]   = p[ch] + 46'h0F_FFFF_FFFF;
      q[ch]    = pc[ch][45:36];
      c3[ch]   = 30'(c_q[ch]) * 30'd3;
      o_d[ch]  = inside_q[1] ? 8'(10'd255 - q[ch]) : c3[ch][29:22];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[ShadeStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    f_q         <= t[19:0];
    root_q[0]   <= root_i;
    root_q[1]   <= root_q[0];
    inside_q[0] <= inside_i;
    inside_q[1] <= inside_q[0];
    for (int ch = 0; ch < 3; ch++) begin
      c0_q[ch] <= wheel_color(ch, k0);
      c1_q[ch] <= wheel_color(ch, k1);
      c_q[ch]  <= mix[ch][27:0];
      o_q[ch]  <= o_d[ch];
    end
  end

  assign valid_o = valid_q[ShadeStages-1];
  assign color_o = o_q;

endmodule

### hdl/optical_flow_color_coder_unit.sv
// Optical flow color coder: one flow vector in, one wheel color out.
// Input channel: an item (flow_u_i, flow_v_i, image_ch0..2_i) is taken at
// each rising edge where start_i is high and busy_o is low. busy_o stays
// low, so an item may enter every cycle; throughput is one item per cycle.
// Output channel: done_o is high for one cycle with out_ch0..2_o valid
// (blue, green, red). After acceptance the item passes through the stages that
// scale and square the vector, then the stages that run the square root and the
// CORDIC angle side by side, then the stages that interpolate and shade, and
// last the register that blends with the image bytes.
// The receiver cannot stall; results are shown exactly once, in order.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 = reciprocal radius, 1 = blend enable); other indexes are ignored.
// Write only while no item is in flight.
// Reset clears all valid bits and sets the reciprocal to 1.0, blending off.
module optical_flow_color_coder_unit import ofcc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] flow_u_i,
  input  logic signed [15:0] flow_v_i,
  input  logic [7:0]         image_ch0_i,
  input  logic [7:0]         image_ch1_i,
  input  logic [7:0]         image_ch2_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  output logic               done_o,
  output logic [7:0]         out_ch0_o,
  output logic [7:0]         out_ch1_o,
  output logic [7:0]         out_ch2_o
);

  localparam int unsigned ImgDepth = Latency - 1;

  logic [31:0]        recip_q;
  logic               blend_q;
  logic               accept;
  logic               nv_valid, it_valid, sh_valid;
  logic [32:0]        nv_r2;
  logic               nv_inside, it_inside;
  logic signed [15:0] nv_u, nv_v;
  logic [16:0]        it_root;
  logic signed [21:0] it_angle;
  logic [7:0]         color [3];
  logic [23:0]        img_q [ImgDepth];
  logic [7:0]         img [3];
  logic [8:0]         sum [3];
  logic [7:0]         out_d [3];
  logic [7:0]         out_q [3];
  logic               done_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recip_q <= 32'd16777216;
      blend_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NORM_RECIP:   recip_q <= cfg_wdata_i;
        CFG_BLEND_ENABLE: blend_q <= cfg_wdata_i[0];
        default:          ;
      endcase
    end
  end

  ofcc_norm u_norm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (accept),
    .flow_u_i     (flow_u_i),
    .flow_v_i     (flow_v_i),
    .norm_recip_i (recip_q),
    .valid_o      (nv_valid),
    .r2_o         (nv_r2),
    .inside_o     (nv_inside),
    .flow_u_o     (nv_u),
    .flow_v_o     (nv_v)
  );

  ofcc_iter u_iter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (nv_valid),
    .r2_i     (nv_r2),
    .inside_i (nv_inside),
    .flow_u_i (nv_u),
    .flow_v_i (nv_v),
    .valid_o  (it_valid),
    .root_o   (it_root),
    .angle_o  (it_angle),
    .inside_o (it_inside)
  );

  ofcc_shade u_shade (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (it_valid),
    .root_i   (it_root),
    .angle_i  (it_angle),
    .inside_i (it_inside),
    .valid_o  (sh_valid),
    .color_o  (color)
  );

  // Image bytes follow the item down a delay line.
  always_ff @(posedge clk_i) begin
    img_q[0] <= {image_ch2_i, image_ch1_i, image_ch0_i};
    for (int i = 1; i < ImgDepth; i++) begin
      img_q[i] <= img_q[i-1];
    end
  end

  assign img[0] = img_q[ImgDepth-1][7:0];
  assign img[1] = img_q[ImgDepth-1][15:8];
  assign img[2] = img_q[ImgDepth-1][23:16];

  // Optional average with the image.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch]   = {1'b0, color[ch]} + {1'b0, img[ch]};
      out_d[ch] = blend_q ? sum[ch][8:1] : color[ch];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= sh_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o    = done_q;
  assign out_ch0_o = out_q[0];
  assign out_ch1_o = out_q[1];
  assign out_ch2_o = out_q[2];

endmodule

### hdl/ofcc_checker.sv
module ofcc_checker import ofcc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o
);

  localparam int unsigned CntWidth = $clog2(Latency + 1);

  logic [CntWidth-1:0] cnt_q;

  // Counts cycles since reset so that look-back stays within the run.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cnt_q != CntWidth'(Latency)) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Every accepted item gives one result a fixed latency later, and nothing else does.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CntWidth'(Latency)) |-> (done_o == $past(start_i && !busy_o, Latency)))
    else $error("result strobe does not match accepted item");

  // The unit never refuses an item.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

  // No result straight out of reset.
  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !done_o)
    else $error("result right after reset");

endmodule

bind optical_flow_color_coder_unit ofcc_checker u_ofcc_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o)
);

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ofcc_pkg::*;

  // Register indexes that the block does not decode.
  localparam logic [1:0] CfgUnused = 2'd3;
  localparam logic [1:0] CfgSpare  = 2'd2;

  typedef struct {
    logic [7:0] ch0;
    logic [7:0] ch1;
    logic [7:0] ch2;
  } color_t;

  // Scoreboard: predicts one color per accepted item and checks results in order.
  class color_scoreboard;
    logic [31:0] recip;
    logic        blend;
    color_t      pending[$];
    int          errors;

    function new();
      recip  = 32'd16777216;
      blend  = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      if (idx == CFG_NORM_RECIP) recip = data;
      else if (idx == CFG_BLEND_ENABLE) blend = data[0];
    endfunction

    // Scale one component to Q.16 and saturate at 2.0.
    function longint scale_comp(longint c);
      longint n;
      n = (c * longint'({32'd0, recip})) >>> 13;
      if (n > NormSat) n = NormSat;
      if (n < -NormSat) n = -NormSat;
      return n;
    endfunction

    // Bitwise square root of a Q.32 value, giving Q.16.
    function longint unsigned root_of(longint unsigned n);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 32;
      for (int i = 0; i < 17; i++) begin
        if (n >= res + bitv) begin
          n   = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // Vectoring CORDIC angle in units of 2^-20 turn.
    function longint heading(longint x, longint y);
      longint z, nx, ny;
      if (y == 0) return (x > 0) ? 0 : -HalfTurn;
      x = x * 16384;
      y = y * 16384;
      z = 0;
      if (x < 0) begin
        if (y > 0) begin
          nx = y;  ny = -x; z = QuarterTurn;
        end else begin
          nx = -y; ny = x;  z = -QuarterTurn;
        end
        x = nx;
        y = ny;
      end
      for (int i = 0; i < CordicSteps; i++) begin
        if (y > 0) begin
          nx = x + (y >>> i); ny = y - (x >>> i); z = z + ATAN_UNITS[i];
        end else begin
          nx = x - (y >>> i); ny = y + (x >>> i); z = z - ATAN_UNITS[i];
        end
        x = nx;
        y = ny;
      end
      if (z > HalfTurn) z = HalfTurn;
      if (z < -HalfTurn) z = -HalfTurn;
      return z;
    endfunction

    function void note_item(logic signed [15:0] u, logic signed [15:0] v,
                            logic [7:0] img0, logic [7:0] img1, logic [7:0] img2);
      longint          un, vn;
      longint unsigned r2, r16, t, k0, k1, f, c, d, o;
      logic            in_disk;
      logic [7:0]      wa, wb, img;
      logic [7:0]      res[3];
      color_t          e;
      un      = scale_comp(longint'(u));
      vn      = scale_comp(longint'(v));
      r2      = un * un + vn * vn;
      in_disk = (r2 <= (64'd1 << 32));
      r16     = in_disk ? root_of(r2) : 0;
      t       = (heading(-longint'(u), -longint'(v)) + HalfTurn) * 54;
      k0      = t >> 20;
      f       = t & 64'hFFFFF;
      k1      = k0 + 1;
      if (k0 >= WheelSize) k0 = WheelSize - 1;
      if (k1 >= WheelSize) k1 = 0;
      for (int ch = 0; ch < 3; ch++) begin
        case (ch)
          0: begin wa = WHEEL_B[k0]; wb = WHEEL_B[k1]; img = img0; end
          1: begin wa = WHEEL_G[k0]; wb = WHEEL_G[k1]; img = img1; end
          default: begin wa = WHEEL_R[k0]; wb = WHEEL_R[k1]; img = img2; end
        endcase
        c = wa * ((64'd1 << 20) - f) + wb * f;
        if (in_disk) begin
          d = 255 * (64'd1 << 20) - c;
          o = 255 - ((r16 * d + ((64'd1 << 36) - 1)) >> 36);
        end else begin
          o = (3 * c) >> 22;
        end
        if (blend) o = (o + img) >> 1;
        res[ch] = o[7:0];
      end
      e.ch0 = res[0];
      e.ch1 = res[1];
      e.ch2 = res[2];
      pending.push_back(e);
    endfunction

    function void check_result(logic [7:0] o0, logic [7:0] o1, logic [7:0] o2);
      color_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Result %0d %0d %0d with no item waiting", o0, o1, o2);
        return;
      end
      e = pending.pop_front();
      if (o0 !== e.ch0 || o1 !== e.ch1 || o2 !== e.ch2) begin
        errors++;
        if (errors <= 10)
          $display("Mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                   e.ch0, e.ch1, e.ch2, o0, o1, o2);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic signed [15:0] flow_u_i;
  logic signed [15:0] flow_v_i;
  logic [7:0]         image_ch0_i;
  logic [7:0]         image_ch1_i;
  logic [7:0]         image_ch2_i;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [31:0]        cfg_wdata_i;
  logic               done_o;
  logic [7:0]         out_ch0_o;
  logic [7:0]         out_ch1_o;
  logic [7:0]         out_ch2_o;

  color_scoreboard sb;
  bit              no_gaps;

  optical_flow_color_coder_unit i_dut (.*);

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Monitor: inputs and outputs are taken at the edge, before any update.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o)
        sb.note_item(flow_u_i, flow_v_i, image_ch0_i, image_ch1_i, image_ch2_i);
      if (done_o) sb.check_result(out_ch0_o, out_ch1_o, out_ch2_o);
    end
  end

  // Hand one item to the block, after a random gap unless no_gaps is set, and wait until it is taken.
  task automatic send_pixel(logic signed [15:0] u, logic signed [15:0] v);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    flow_u_i    <= u;
    flow_v_i    <= v;
    image_ch0_i <= 8'($urandom);
    image_ch1_i <= 8'($urandom);
    image_ch2_i <= 8'($urandom);
    do @(posedge clk_i); while (busy_o);
  endtask

  // Let the pipeline drain before a register write.
  task automatic wait_idle();
    start_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random component: uniform between -bound and bound.
  function automatic logic signed [15:0] rand_comp(int bound);
    int r;
    r = $urandom_range(0, 2 * bound) - bound;
    return 16'(r);
  endfunction

  logic [31:0] recips[6];

  initial begin
    int bound;
    sb          = new();
    no_gaps     = 1'b0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    flow_u_i    = '0;
    flow_v_i    = '0;
    image_ch0_i = '0;
    image_ch1_i = '0;
    image_ch2_i = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_NORM_RECIP;
    cfg_wdata_i = '0;
    recips      = '{32'd16777216, 32'd0, 32'hFFFFFFFF, 32'd1048576, 32'd1, 32'd33554432};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items at reset settings: axes, zero vector, extremes, diagonals.
    send_pixel(16'sd0, 16'sd0);
    send_pixel(16'sd32, 16'sd0);
    send_pixel(-16'sd32, 16'sd0);
    send_pixel(16'sd0, 16'sd32);
    send_pixel(16'sd0, -16'sd32);
    send_pixel(16'sd20, 16'sd20);
    send_pixel(-16'sd20, 16'sd20);
    send_pixel(16'sd20, -16'sd20);
    send_pixel(-16'sd20, -16'sd20);
    send_pixel(16'sd32767, 16'sd32767);
    send_pixel(-16'sd32768, -16'sd32768);
    send_pixel(-16'sd32768, 16'sd32767);
    send_pixel(16'sd32767, 16'sd0);
    send_pixel(-16'sd32768, 16'sd0);
    send_pixel(16'sd0, -16'sd32768);
    send_pixel(16'sd5, -16'sd31);
    send_pixel(16'sd45, 16'sd1);
    send_pixel(-16'sd1, -16'sd1);

    // Writes to an unknown index must change nothing.
    wait_idle();
    write_reg(CfgUnused, 32'h0);
    write_reg(CfgSpare, 32'hFFFFFFFF);
    send_pixel(16'sd10, -16'sd7);
    send_pixel(16'sd0, 16'sd0);

    // Phases over the reciprocal settings, blending toggled between them.
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      write_reg(CFG_NORM_RECIP, (ph == 5) ? $urandom : recips[ph]);
      write_reg(CFG_BLEND_ENABLE, {31'($urandom), ph[0]});
      for (int n = 0; n < 140; n++) begin
        if (n % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 3))
          0:       bound = 40;
          1:       bound = 600;
          2:       bound = 8;
          default: bound = 32767;
        endcase
        if ($urandom_range(0, 9) == 0) send_pixel(rand_comp(bound), 16'sd0);
        else send_pixel(16'($urandom), 16'($urandom) >>> ($urandom_range(0, 1) * 14))
          ;
        if (bound != 32767) send_pixel(rand_comp(bound), rand_comp(bound));
      end
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
